// ===== sv/cmm_pkg.sv =====
// Shared constants, codes and control structs for the complex matrix multiplier.
`timescale 1ns / 1ps

package cmm_pkg;

    localparam int DEF_MAX_DIM       = 16;
    localparam int DEF_ELEMENT_WIDTH = 16;

    localparam int ACC_W       = 37;  // exact dot-product width
    localparam int IDX_FIELD_W = 4;   // row/col fields on the ports
    localparam int ACTION_W    = 2;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD_LEFT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_RIGHT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic wr_left;
        logic wr_right;
        logic issue;
        logic first;
        logic last_k;
        logic zero;
        logic last_col;
    } t_cmd;

    typedef struct packed {
        logic read_pending;
        logic mul_pending;
    } t_status;

endpackage

// ===== sv/cmm_ctrl.sv =====
// Controller: size registers, request decode and the row sequencer.
`timescale 1ns / 1ps

module cmm_ctrl import cmm_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic [IDX_FIELD_W-1:0] i_row_index,
    input  logic [IDX_FIELD_W-1:0] i_col_index,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  t_status                i_status,
    output logic                   o_busy,
    output t_cmd                   o_cmd,
    output logic [$clog2(MAX_DIM)-1:0] o_k,
    output logic [$clog2(MAX_DIM)-1:0] o_c,
    output logic [IDX_FIELD_W-1:0] o_row
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_k, n_k;
    logic [IDX_W-1:0]       r_c, n_c;
    logic [IDX_FIELD_W-1:0] r_row, n_row;
    logic [CFG_W-1:0]       r_rows, r_inner, r_cols;

    logic [DIM_W-1:0] nrows, ninner, ncols;
    logic             accept;
    logic             ld_left_ok, ld_right_ok, cmp_ok;
    logic             last_k, last_c;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    assign nrows  = clamp_dim(r_rows);
    assign ninner = clamp_dim(r_inner);
    assign ncols  = clamp_dim(r_cols);

    assign accept      = i_start && (r_state == S_IDLE);
    assign ld_left_ok  = (int'(i_row_index) < int'(nrows)) && (int'(i_col_index) < int'(ninner));
    assign ld_right_ok = (int'(i_row_index) < int'(ninner)) && (int'(i_col_index) < int'(ncols));
    assign cmp_ok      = (int'(i_row_index) < int'(nrows)) && (ncols != '0);

    // empty inner dimension still walks one zero term per column
    assign last_k = (ninner == '0) || (int'(r_k) + 1 == int'(ninner));
    assign last_c = (int'(r_c) + 1 == int'(ncols));

    always_comb begin
        o_cmd.wr_left  = accept && (i_action == ACT_LOAD_LEFT) && ld_left_ok;
        o_cmd.wr_right = accept && (i_action == ACT_LOAD_RIGHT) && ld_right_ok;
        o_cmd.issue    = (r_state == S_RUN);
        o_cmd.first    = (r_k == '0);
        o_cmd.last_k   = last_k;
        o_cmd.zero     = (ninner == '0);
        o_cmd.last_col = last_c;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_k    = r_k;
    assign o_c    = r_c;
    assign o_row  = r_row;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_c     = r_c;
        n_row   = r_row;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_COMPUTE) && cmp_ok) begin
                    n_state = S_RUN;
                    n_k     = '0;
                    n_c     = '0;
                    n_row   = i_row_index;
                end
            end
            S_RUN: begin
                if (last_k) begin
                    n_k = '0;
                    if (last_c) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                // leave once the final term has passed the store read
                if (!i_status.read_pending) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_c     <= '0;
            r_row   <= '0;
            r_rows  <= CFG_RESET;
            r_inner <= CFG_RESET;
            r_cols  <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_c     <= n_c;
            r_row   <= n_row;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROWS:  r_rows  <= i_cfg_data;
                    REG_INNER: r_inner <= i_cfg_data;
                    REG_COLS:  r_cols  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sv/cmm_datapath.sv =====
// Datapath: element stores, complex multiplier and accumulator, result register.
`timescale 1ns / 1ps

module cmm_datapath import cmm_pkg::*; #(
    parameter int MAX_DIM       = DEF_MAX_DIM,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    input  logic [$clog2(MAX_DIM)-1:0]      i_k,
    input  logic [$clog2(MAX_DIM)-1:0]      i_c,
    input  logic [IDX_FIELD_W-1:0]          i_row,
    input  logic [IDX_FIELD_W-1:0]          i_ld_row,
    input  logic [IDX_FIELD_W-1:0]          i_ld_col,
    input  logic signed [ELEMENT_WIDTH-1:0] i_real_in,
    input  logic signed [ELEMENT_WIDTH-1:0] i_imag_in,
    output t_status                         o_status,
    output logic                            o_valid,
    output logic [IDX_FIELD_W-1:0]          o_out_row,
    output logic [IDX_FIELD_W-1:0]          o_out_col,
    output logic signed [ACC_W-1:0]         o_real_out,
    output logic signed [ACC_W-1:0]         o_imag_out,
    output logic                            o_last
);

    localparam int EW     = ELEMENT_WIDTH;
    localparam int ELEM_W = 2 * EW;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // {imag, real} per element, row-major
    logic [ELEM_W-1:0] r_left_mem  [DEPTH];
    logic [ELEM_W-1:0] r_right_mem [DEPTH];

    logic [ADDR_W-1:0] wr_addr, left_rd_addr, right_rd_addr;

    // read stage
    logic [ELEM_W-1:0]      r_a_left, r_a_right;
    logic                   r_a_valid;
    logic                   r_a_first, r_a_last_k, r_a_zero, r_a_last_col;
    logic [IDX_FIELD_W-1:0] r_a_row, r_a_col;

    // multiply stage
    logic signed [ACC_W-1:0] r_b_rr, r_b_ii, r_b_ri, r_b_ir;
    logic                    r_b_valid;
    logic                    r_b_first, r_b_last_k, r_b_last_col;
    logic [IDX_FIELD_W-1:0]  r_b_row, r_b_col;

    // accumulate stage
    logic signed [ACC_W-1:0] r_acc_re, r_acc_im, n_acc_re, n_acc_im;
    logic signed [ACC_W-1:0] term_re, term_im;
    logic                    r_out_valid;
    logic [IDX_FIELD_W-1:0]  r_out_row, r_out_col;
    logic signed [ACC_W-1:0] r_out_re, r_out_im;
    logic                    r_out_last;

    logic signed [EW-1:0]     a_re, a_im, b_re, b_im;
    logic signed [2*EW-1:0]   p_rr, p_ii, p_ri, p_ir;

    assign wr_addr       = ADDR_W'(int'(i_ld_row) * MAX_DIM + int'(i_ld_col));
    assign left_rd_addr  = ADDR_W'(int'(i_row) * MAX_DIM + int'(i_k));
    assign right_rd_addr = ADDR_W'(int'(i_k) * MAX_DIM + int'(i_c));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_left) begin
            r_left_mem[wr_addr] <= {i_imag_in, i_real_in};
        end
        r_a_left <= r_left_mem[left_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_right) begin
            r_right_mem[wr_addr] <= {i_imag_in, i_real_in};
        end
        r_a_right <= r_right_mem[right_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_cmd.issue;
        end
        r_a_first    <= i_cmd.first;
        r_a_last_k   <= i_cmd.last_k;
        r_a_zero     <= i_cmd.zero;
        r_a_last_col <= i_cmd.last_col;
        r_a_row      <= i_row;
        r_a_col      <= IDX_FIELD_W'(i_c);
    end

    assign a_re = r_a_left[EW-1:0];
    assign a_im = r_a_left[ELEM_W-1:EW];
    assign b_re = r_a_right[EW-1:0];
    assign b_im = r_a_right[ELEM_W-1:EW];

    always_comb begin
        p_rr = a_re * b_re;
        p_ii = a_im * b_im;
        p_ri = a_re * b_im;
        p_ir = a_im * b_re;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        if (r_a_zero) begin
            r_b_rr <= '0;
            r_b_ii <= '0;
            r_b_ri <= '0;
            r_b_ir <= '0;
        end else begin
            r_b_rr <= ACC_W'(p_rr);
            r_b_ii <= ACC_W'(p_ii);
            r_b_ri <= ACC_W'(p_ri);
            r_b_ir <= ACC_W'(p_ir);
        end
        r_b_first    <= r_a_first;
        r_b_last_k   <= r_a_last_k;
        r_b_last_col <= r_a_last_col;
        r_b_row      <= r_a_row;
        r_b_col      <= r_a_col;
    end

    always_comb begin
        term_re  = r_b_rr - r_b_ii;
        term_im  = r_b_ri + r_b_ir;
        n_acc_re = r_b_first ? term_re : r_acc_re + term_re;
        n_acc_im = r_b_first ? term_im : r_acc_im + term_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_b_valid && r_b_last_k;
        end
        if (r_b_valid) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
        if (r_b_valid && r_b_last_k) begin
            r_out_re   <= n_acc_re;
            r_out_im   <= n_acc_im;
            r_out_row  <= r_b_row;
            r_out_col  <= r_b_col;
            r_out_last <= r_b_last_col;
        end
    end

    assign o_status.read_pending = r_a_valid;
    assign o_status.mul_pending  = r_b_valid;

    assign o_valid    = r_out_valid;
    assign o_out_row  = r_out_row;
    assign o_out_col  = r_out_col;
    assign o_real_out = r_out_re;
    assign o_imag_out = r_out_im;
    assign o_last     = r_out_last;

endmodule

// ===== sv/complex_matrix_multiply.sv =====
// Load request: busy stays low. Compute request: busy until every term has left the store
// read; each column's result passes the read, multiply and accumulate stages after its last term issues.
// One complex multiply-accumulate per cycle, set by the single read port of each element store.
// Results are strobed for one cycle on o_valid; the receiver cannot stall them.
// Reset is synchronous, active low: control clears and sizes return to 16; stores are not cleared.
`timescale 1ns / 1ps

module complex_matrix_multiply import cmm_pkg::*; #(
    parameter int MAX_DIM       = DEF_MAX_DIM,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ACTION_W-1:0]             i_action,
    input  logic [IDX_FIELD_W-1:0]          i_row_index,
    input  logic [IDX_FIELD_W-1:0]          i_col_index,
    input  logic signed [ELEMENT_WIDTH-1:0] i_real_in,
    input  logic signed [ELEMENT_WIDTH-1:0] i_imag_in,
    input  logic                            i_cfg_we,
    input  logic [CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [CFG_W-1:0]                i_cfg_data,
    output logic                            o_valid,
    output logic [IDX_FIELD_W-1:0]          o_out_row,
    output logic [IDX_FIELD_W-1:0]          o_out_col,
    output logic signed [ACC_W-1:0]         o_real_out,
    output logic signed [ACC_W-1:0]         o_imag_out,
    output logic                            o_last
);

    localparam int IDX_W = $clog2(MAX_DIM);

    t_cmd                   cmd;
    t_status                status;
    logic [IDX_W-1:0]       seq_k, seq_c;
    logic [IDX_FIELD_W-1:0] seq_row;

    cmm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_action    (i_action),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_busy      (busy),
        .o_cmd       (cmd),
        .o_k         (seq_k),
        .o_c         (seq_c),
        .o_row       (seq_row)
    );

    cmm_datapath #(
        .MAX_DIM       (MAX_DIM),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_k        (seq_k),
        .i_c        (seq_c),
        .i_row      (seq_row),
        .i_ld_row   (i_row_index),
        .i_ld_col   (i_col_index),
        .i_real_in  (i_real_in),
        .i_imag_in  (i_imag_in),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_out_row  (o_out_row),
        .o_out_col  (o_out_col),
        .o_real_out (o_real_out),
        .o_imag_out (o_imag_out),
        .o_last     (o_last)
    );

`ifndef SYNTHESIS
    // a result only follows a cycle in which a row was being worked
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding compute");

    // the pipeline is empty before the row's final result shows
    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !status.read_pending && !status.mul_pending)
        else $error("terms still in flight after final column");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> !o_valid)
        else $error("result directly after final column");

    // back-to-back results step through the columns in order
    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && !$past(o_last) |->
            o_out_col == IDX_FIELD_W'($past(o_out_col) + 1'b1))
        else $error("column order broken");
`endif

endmodule
